@@ sv/gmd_pkg.sv @@
// shared types, constants and widths for the gradient magnetometer detector
package gmd_pkg;

    // counter width of the two sensor channels
    localparam int COUNT_WIDTH = 16;
    localparam int DEV_W       = COUNT_WIDTH + 1;

    // input beat layout
    localparam int POT_W       = 10;
    localparam int BATT_W      = 10;
    localparam int IN_BITS     = 2 * COUNT_WIDTH + 2 + POT_W + BATT_W;
    localparam int IN_TDATA_W  = ((IN_BITS + 7) / 8) * 8;

    // output beat layout
    localparam int METER_W     = 8;
    localparam int THR_W       = 7;
    localparam int OUT_BITS    = METER_W + 4 + THR_W;
    localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

    // configuration port
    localparam int APB_ADDR_W  = 3;
    localparam int APB_DATA_W  = 32;
    localparam int LIMIT_W     = 8;
    localparam int DELAY_W     = 16;

    localparam logic REG_BATTERY_LIMIT = 1'b0;
    localparam logic REG_BATTERY_DELAY = 1'b1;

    localparam logic [LIMIT_W-1:0] BATTERY_LIMIT_RST = LIMIT_W'(200);
    localparam logic [DELAY_W-1:0] BATTERY_DELAY_RST = DELAY_W'(1000);

    // datapath constants
    localparam logic [METER_W-1:0] METER_CENTER = METER_W'(127);
    localparam logic [THR_W-1:0]   THR_MIN      = THR_W'(2);
    localparam logic [THR_W-1:0]   THR_MAX      = THR_W'(125);
    localparam logic [THR_W-1:0]   THR_RST      = THR_W'(2);
    localparam int                 DEV_LOW      = -127;
    localparam int                 DEV_HIGH     = 128;
    localparam int                 BASELINE_RST = 127;

    localparam logic [1:0] TONE_POS = 2'd1;
    localparam logic [1:0] TONE_NEG = 2'd2;
    localparam logic [1:0] TONE_OFF = 2'd0;

    // input item, last field in the low bits
    typedef struct packed {
        logic [BATT_W-1:0]      battery_reading;
        logic [POT_W-1:0]       pot_reading;
        logic                   cal_pressed;
        logic                   full_sens;
        logic [COUNT_WIDTH-1:0] count_b;
        logic [COUNT_WIDTH-1:0] count_a;
    } in_item_t;

    // result item, last field in the low bits
    typedef struct packed {
        logic [THR_W-1:0]   threshold_now;
        logic               low_battery_alarm;
        logic               sensor_error;
        logic               led_on;
        logic               beep_level;
        logic [METER_W-1:0] meter_duty;
    } out_item_t;

    // register file contents seen by the datapath
    typedef struct packed {
        logic [LIMIT_W-1:0] battery_limit;
        logic [DELAY_W-1:0] battery_delay;
    } cfg_t;

endpackage

@@ sv/gmd_cfg.sv @@
// apb register file for battery limit and battery delay
module gmd_cfg
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [gmd_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [gmd_pkg::APB_DATA_W-1:0] pwdata,
    output logic [gmd_pkg::APB_DATA_W-1:0] prdata,
    output logic                          pready,
    output gmd_pkg::cfg_t                 cfg
);
    import gmd_pkg::*;

    logic [LIMIT_W-1:0] limit_reg;
    logic [DELAY_W-1:0] delay_reg;
    logic               wr_en;
    logic               reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_sel = paddr[2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= BATTERY_LIMIT_RST;
            delay_reg <= BATTERY_DELAY_RST;
        end
        else if (wr_en)
        begin
            case (reg_sel)
                REG_BATTERY_LIMIT: limit_reg <= pwdata[LIMIT_W-1:0];
                REG_BATTERY_DELAY: delay_reg <= pwdata[DELAY_W-1:0];
                default:           limit_reg <= limit_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_sel)
            REG_BATTERY_LIMIT: prdata = APB_DATA_W'(limit_reg);
            REG_BATTERY_DELAY: prdata = APB_DATA_W'(delay_reg);
            default:           prdata = '0;
        endcase
    end

    assign cfg.battery_limit = limit_reg;
    assign cfg.battery_delay = delay_reg;

endmodule

@@ sv/gmd_core.sv @@
// detector state and the single-pass window / tick datapath
module gmd_core
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              advance,
    input  logic              is_tick,
    input  gmd_pkg::in_item_t item,
    input  gmd_pkg::cfg_t     cfg,
    output gmd_pkg::out_item_t result
);
    import gmd_pkg::*;

    logic signed [COUNT_WIDTH-1:0] baseline_reg, baseline_next;
    logic [THR_W-1:0]              thr_reg, thr_next;
    logic [THR_W-1:0]              pot_prev_reg, pot_prev_next;
    logic [1:0]                    tone_cnt_reg, tone_cnt_next;
    logic [1:0]                    tone_div_reg, tone_div_next;
    logic                          beep_reg, beep_next;
    logic                          led_reg, led_next;
    logic [METER_W-1:0]            meter_reg, meter_next;
    logic [DELAY_W-1:0]            batt_cnt_reg, batt_cnt_next;

    logic signed [COUNT_WIDTH-1:0] diff_raw, diff_scaled;
    logic signed [DEV_W-1:0]       dev_full;
    logic signed [8:0]             dev_clamp;
    logic [8:0]                    dev_mag;
    logic [THR_W-1:0]              pot_cand, pot_gap, thr_pick;
    logic [LIMIT_W-1:0]            batt_level;
    logic [1:0]                    tone_dec;
    logic                          err, alarm;

    always_comb
    begin
        // window arithmetic, evaluated for every beat
        diff_raw    = $signed(item.count_a - item.count_b);
        diff_scaled = item.full_sens ? diff_raw : (diff_raw >>> 2);
        baseline_next = item.cal_pressed ? diff_scaled : baseline_reg;
        dev_full    = DEV_W'(diff_scaled) - DEV_W'(baseline_next);
        if (dev_full < $signed(DEV_W'(DEV_LOW)))
            dev_clamp = 9'(DEV_LOW);
        else if (dev_full > $signed(DEV_W'(DEV_HIGH)))
            dev_clamp = 9'(DEV_HIGH);
        else
            dev_clamp = 9'(dev_full);
        dev_mag     = dev_clamp[8] ? 9'(-dev_clamp) : 9'(dev_clamp);

        pot_cand    = item.pot_reading[POT_W-1:3];
        pot_gap     = (pot_cand > pot_prev_reg) ? (pot_cand - pot_prev_reg)
                                                : (pot_prev_reg - pot_cand);
        thr_pick    = (pot_gap > THR_W'(1)) ? pot_cand : thr_reg;
        if (thr_pick < THR_MIN)
            thr_pick = THR_MIN;
        else if (thr_pick > THR_MAX)
            thr_pick = THR_MAX;

        batt_level  = item.battery_reading[BATT_W-1:2];
        tone_dec    = tone_cnt_reg - 2'd1;

        // defaults hold the state
        thr_next      = thr_reg;
        pot_prev_next = pot_prev_reg;
        tone_cnt_next = tone_cnt_reg;
        tone_div_next = tone_div_reg;
        beep_next     = beep_reg;
        led_next      = led_reg;
        meter_next    = meter_reg;
        batt_cnt_next = batt_cnt_reg;
        err           = 1'b0;
        alarm         = 1'b0;

        if (is_tick)
        begin
            baseline_next = baseline_reg;
            if (tone_cnt_reg != 2'd0)
            begin
                tone_cnt_next = tone_dec;
                if (tone_dec == 2'd0)
                begin
                    beep_next     = ~beep_reg;
                    tone_cnt_next = tone_div_reg;
                end
            end
            else
            begin
                tone_cnt_next = tone_div_reg;
            end
        end
        else
        begin
            err           = (item.count_a == '0) || (item.count_b == '0);
            meter_next    = dev_clamp[METER_W-1:0] + METER_CENTER;
            thr_next      = thr_pick;
            pot_prev_next = pot_cand;
            if (dev_mag > 9'(thr_pick))
            begin
                tone_cnt_next = dev_clamp[8] ? TONE_NEG : TONE_POS;
                tone_div_next = dev_clamp[8] ? TONE_NEG : TONE_POS;
                led_next      = 1'b1;
            end
            else
            begin
                tone_cnt_next = TONE_OFF;
                tone_div_next = TONE_OFF;
                led_next      = 1'b0;
            end
            if (batt_level < cfg.battery_limit)
            begin
                if (batt_cnt_reg != '0)
                    batt_cnt_next = batt_cnt_reg - DELAY_W'(1);
                else
                begin
                    batt_cnt_next = cfg.battery_delay;
                    alarm         = 1'b1;
                end
            end
            else
            begin
                batt_cnt_next = cfg.battery_delay;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            baseline_reg <= COUNT_WIDTH'(BASELINE_RST);
            thr_reg      <= THR_RST;
            pot_prev_reg <= '0;
            tone_cnt_reg <= '0;
            tone_div_reg <= '0;
            beep_reg     <= 1'b0;
            led_reg      <= 1'b0;
            meter_reg    <= METER_CENTER;
            batt_cnt_reg <= BATTERY_DELAY_RST;
        end
        else if (advance)
        begin
            baseline_reg <= baseline_next;
            thr_reg      <= thr_next;
            pot_prev_reg <= pot_prev_next;
            tone_cnt_reg <= tone_cnt_next;
            tone_div_reg <= tone_div_next;
            beep_reg     <= beep_next;
            led_reg      <= led_next;
            meter_reg    <= meter_next;
            batt_cnt_reg <= batt_cnt_next;
        end
    end

    assign result.meter_duty        = meter_next;
    assign result.beep_level        = beep_next;
    assign result.led_on            = led_next;
    assign result.sensor_error      = err;
    assign result.low_battery_alarm = alarm;
    assign result.threshold_now     = thr_next;

endmodule

@@ sv/gradient_magnetometer_detector.sv @@
// top level: input register, detector datapath, result register, apb registers
//
// channel   | dir | beat contents
// ----------+-----+-------------------------------------------------------------
// s_axis    | in  | window or tone tick; tuser = func (1 tick, 0 window)
// m_axis    | out | one result beat per input beat
// apb       | in  | 0x0 battery_limit, 0x4 battery_delay
//
// each beat passes through the input register and then the result
// register; one beat per cycle sustained while m_axis_tready is high
// the whole window evaluation (subtract, clamp, threshold, battery count)
// sits between those two registers
// rst_n asynchronously clears all but the payload registers to reset values
// a stall on m_axis holds the result; the input register still takes one
// more beat, then s_axis_tready drops
module gradient_magnetometer_detector
(
    input  logic                             clk,
    input  logic                             rst_n,
    // slave stream
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // count_a, count_b, full_sens, cal_pressed, pot_reading,
    // battery_reading, zero pad (low bit up)
    input  logic [gmd_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    // func
    input  logic                             s_axis_tuser,
    // master stream
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // meter_duty, beep_level, led_on, sensor_error, low_battery_alarm,
    // threshold_now, zero pad (low bit up)
    output logic [gmd_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
    // configuration
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [gmd_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [gmd_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [gmd_pkg::APB_DATA_W-1:0]   prdata,
    output logic                             pready
);
    import gmd_pkg::*;

    cfg_t      cfg;
    in_item_t  in_item_reg;
    logic      in_tick_reg;
    logic      in_valid_reg, in_valid_next;
    out_item_t out_item_reg;
    logic      out_valid_reg, out_valid_next;
    out_item_t result;
    logic      in_beat;
    logic      advance;

    gmd_cfg u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // an item moves into the result register when that register is free
    // or being emptied in the same cycle
    assign advance       = in_valid_reg & (~out_valid_reg | m_axis_tready);
    assign s_axis_tready = ~in_valid_reg | advance;
    assign in_beat       = s_axis_tvalid & s_axis_tready;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_beat)
            in_valid_next = 1'b1;
        else if (advance)
            in_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (advance)
            out_valid_next = 1'b1;
        else if (m_axis_tready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge clk)
    begin
        if (in_beat)
        begin
            in_item_reg <= in_item_t'(s_axis_tdata[IN_BITS-1:0]);
            in_tick_reg <= s_axis_tuser;
        end
        if (advance)
            out_item_reg <= result;
    end

    gmd_core u_core
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .is_tick (in_tick_reg),
        .item    (in_item_reg),
        .cfg     (cfg),
        .result  (result)
    );

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = OUT_TDATA_W'(out_item_reg);

    // a full input register behind a stalled output must stop new beats
    a_backpressure : assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && out_valid_reg && !m_axis_tready) |-> !s_axis_tready)
        else $error("input accepted while both stages are blocked");

    // a result shown is always within the clamped threshold range
    a_threshold_range : assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (out_item_reg.threshold_now >= THR_MIN &&
                           out_item_reg.threshold_now <= THR_MAX))
        else $error("threshold outside its clamp range");

    // led on means the deviation beat the threshold, so the meter is off center
    a_led_meter : assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && out_item_reg.led_on) |->
            (out_item_reg.meter_duty < METER_CENTER - METER_W'(2) ||
             out_item_reg.meter_duty > METER_CENTER + METER_W'(2)))
        else $error("led lit with meter near center");

endmodule
